/* rtl/core/scma_pkg.sv */
// scma_pkg: shared types and fixed-point constants of the sine/cosine unit
// no dependencies
package scma_pkg;

	localparam int ANGLE_W  = 32;
	localparam int RESULT_W = 32;
	localparam int VAL_W    = 48;
	localparam int FRAC     = 40;
	localparam int RES_FRAC = 30;

	// internal value: two's complement, FRAC fraction bits
	typedef logic signed [VAL_W-1:0] val_t;

	// pi * 2^60 and 1/(2pi) * 2^64, both fit in 62 bits
	localparam logic [61:0] PI_Q60    = 62'h3243F6A8885A308D;
	localparam logic [61:0] INV2PI_Q64 = 62'h28BE60DB9391054A;

	localparam logic [63:0] ONE64 = 64'd1 << FRAC;

	// pi/8 and pi/16 at FRAC fraction bits, rounded
	localparam logic [63:0] PI8_Q40  = ({2'b00, PI_Q60} + (64'd1 << 22)) >> 23;
	localparam logic [63:0] PI16_Q40 = ({2'b00, PI_Q60} + (64'd1 << 23)) >> 24;

	localparam val_t ONE_V = val_t'(ONE64);

	// cosine taylor coefficients round(2^F/(2n)!), alternating sign
	localparam val_t COEF [0:6] = '{
		val_t'(ONE64),
		-val_t'((ONE64 + 64'd1) / 64'd2),
		val_t'((ONE64 + 64'd12) / 64'd24),
		-val_t'((ONE64 + 64'd360) / 64'd720),
		val_t'((ONE64 + 64'd20160) / 64'd40320),
		-val_t'((ONE64 + 64'd1814400) / 64'd3628800),
		val_t'((ONE64 + 64'd239500800) / 64'd479001600)
	};

endpackage

/* rtl/core/scma_mac.sv */
// scma_mac: three-stage fixed-point multiply-add, y = addend + (1 or 2)*round(a*b/2^F)
// depends on scma_pkg
module scma_mac #(
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  scma_pkg::val_t      a,
	input  scma_pkg::val_t      b,
	input  scma_pkg::val_t      addend,
	input  logic                dbl,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                out_valid,
	output scma_pkg::val_t      y,
	output logic [SIDE_W-1:0]   side_out
);
	import scma_pkg::*;

	logic [VAL_W-1:0] ma, mb;
	logic             v_s1, v_s2, v_s3;
	logic [45:0]      hh_s1;
	logic [46:0]      hl_s1, lh_s1;
	logic [47:0]      ll_s1;
	logic             neg_s1, neg_s2;
	logic             dbl_s1, dbl_s2;
	val_t             add_s1, add_s2, y_s3;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3;
	logic [47:0]      mid;
	logic [94:0]      prod;
	logic [46:0]      q_s2;
	val_t             sq;

	assign ma = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
	assign mb = b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);

	// partial products summed, rounded half away from zero
	assign mid  = 48'(hl_s1) + 48'(lh_s1);
	assign prod = {hh_s1, 48'b0} + {23'b0, mid, 24'b0} + {47'b0, ll_s1}
		+ (95'd1 << (FRAC - 1));

	assign sq = neg_s2 ? -val_t'({1'b0, q_s2}) : val_t'({1'b0, q_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1   <= ma[46:24] * mb[46:24];
			hl_s1   <= ma[46:24] * mb[23:0];
			lh_s1   <= ma[23:0] * mb[46:24];
			ll_s1   <= ma[23:0] * mb[23:0];
			neg_s1  <= a[VAL_W-1] ^ b[VAL_W-1];
			dbl_s1  <= dbl;
			add_s1  <= addend;
			side_s1 <= side_in;

			q_s2    <= prod[FRAC+46:FRAC];
			neg_s2  <= neg_s1;
			dbl_s2  <= dbl_s1;
			add_s2  <= add_s1;
			side_s2 <= side_s1;

			y_s3    <= (dbl_s2 ? (sq <<< 1) : sq) + add_s2;
			side_s3 <= side_s2;
		end
	end

	assign out_valid = v_s3;
	assign y         = y_s3;
	assign side_out  = side_s3;

endmodule

/* rtl/core/scma_reduce.sv */
// scma_reduce: six-stage angle reduction, gives r = (angle - k*2pi)/8, minus pi/16 for sine
// depends on scma_pkg
module scma_reduce (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic                 func,
	input  logic                 quick,
	input  logic signed [31:0]   angle,
	output logic                 out_valid,
	output logic                 out_quick,
	output scma_pkg::val_t       r
);
	import scma_pkg::*;

	logic [31:0]        mag_a;
	logic [5:0]         v;
	logic               func_s1, func_s2, func_s3, func_s4, func_s5;
	logic               quick_s1, quick_s2, quick_s3, quick_s4, quick_s5, quick_s6;
	logic signed [31:0] ang_s1, ang_s2, ang_s3;
	logic [62:0]        phi_s1, plo_s1;
	logic               neg_s1;
	logic [94:0]        prod;
	logic [54:0]        q;
	logic signed [55:0] t, t_s2;
	logic [55:0]        tmag;
	logic signed [15:0] k, k_s3;
	logic signed [79:0] kp;
	logic [63:0]        d, d_s4, dmag;
	logic [46:0]        m, m_s5;
	logic               neg_s5;
	val_t               rs, r_s6;

	// stage 1: |angle| times 1/(2pi), split in two halves
	assign mag_a = angle[31] ? 32'(-angle) : 32'(angle);

	// stage 2: round to Q40, add pi/8
	assign prod = {phi_s1, 31'b0} + {31'b0, plo_s1} + (95'd1 << (FRAC - 1));
	assign q    = {1'b0, prod[93:FRAC]};
	assign t    = (neg_s1 ? -56'(signed'(q)) : 56'(signed'(q))) + 56'(PI8_Q40);

	// stage 3: k = trunc(t / 2^40)
	assign tmag = t_s2[55] ? 56'(-t_s2) : 56'(t_s2);
	assign k    = t_s2[55] ? -16'(signed'(tmag[55:FRAC])) : 16'(signed'(tmag[55:FRAC]));

	// stage 4: angle*2^59 - k*pi*2^60, low 64 bits are exact
	assign kp = k_s3 * $signed({2'b00, PI_Q60});
	assign d  = {ang_s3[20:0], 43'b0} - kp[63:0];

	// stage 5: rounded shift to Q40, sign-magnitude
	assign dmag = d_s4[63] ? 64'(-d_s4) : d_s4;
	assign m    = 47'(dmag[63:22]) + 47'(dmag[21]);

	// stage 6: restore sign, sine offset
	assign rs = (neg_s5 ? -val_t'({1'b0, m_s5}) : val_t'({1'b0, m_s5}))
		- (func_s5 ? val_t'(0) : val_t'(PI16_Q40));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else if (en) begin
			v <= {v[4:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phi_s1   <= mag_a * INV2PI_Q64[61:31];
			plo_s1   <= mag_a * INV2PI_Q64[30:0];
			neg_s1   <= angle[31];
			ang_s1   <= angle;
			func_s1  <= func;
			quick_s1 <= quick;

			t_s2     <= t;
			ang_s2   <= ang_s1;
			func_s2  <= func_s1;
			quick_s2 <= quick_s1;

			k_s3     <= k;
			ang_s3   <= ang_s2;
			func_s3  <= func_s2;
			quick_s3 <= quick_s2;

			d_s4     <= d;
			func_s4  <= func_s3;
			quick_s4 <= quick_s3;

			m_s5     <= m;
			neg_s5   <= d_s4[63];
			func_s5  <= func_s4;
			quick_s5 <= quick_s4;

			r_s6     <= rs;
			quick_s6 <= quick_s5;
		end
	end

	assign out_valid = v[5];
	assign out_quick = quick_s6;
	assign r         = r_s6;

endmodule

/* rtl/core/sine_cosine_multiple_angle.sv */
// sine_cosine_multiple_angle: pipelined sine/cosine by eighth-angle reduction,
// even taylor polynomial and the 8th-angle chebyshev identity
// depends on scma_pkg, scma_reduce, scma_mac
//
// usage
// - input channel: angle (signed Q16.16 radians) and func (0 sine, 1 cosine),
//   a transfer on angle_valid high and angle_stall low
// - output channel: result (signed Q2.30, saturated to plus or minus one),
//   a transfer on result_valid high and result_stall low
// - config channel: cfg_data bit 0 sets quick mode (three-term polynomial),
//   cfg_ready is always high; write only while the pipe is empty
// - pipeline: 6 reduction stages, 3 for r*r, 6 horner steps and
//   3 chebyshev squarings of 3 stages each, one output stage
// - throughput one item per cycle while the output is not stalled; the ten
//   three-stage multiply-add units in series set most of the stage count
// - a stall on the output freezes the whole pipe and raises angle_stall,
//   nothing is dropped or repeated
// - reset clears all valid bits and quick mode
module sine_cosine_multiple_angle (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               angle_valid,
	output logic               angle_stall,
	input  logic               func,
	input  logic signed [31:0] angle,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);
	import scma_pkg::*;

	logic               en;
	logic               quick_mode_q;
	logic               r_valid, r_quick;
	val_t               r;
	logic               u_valid;
	logic               u_quick;
	val_t               u;
	// horner chain
	logic               hv [0:6];
	logic               hq [0:6];
	val_t               hu [0:6];
	val_t               hp [0:6];
	// chebyshev chain
	logic               cv [0:3];
	val_t               cy [0:3];
	logic [VAL_W-1:0]   ymag;
	logic [37:0]        om;
	logic [31:0]        omc;
	logic               res_valid_q;
	logic signed [31:0] res_q;

	// whole pipe advances unless a finished result is held back
	assign en          = !(res_valid_q && result_stall);
	assign angle_stall = !en;
	assign cfg_ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quick_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			quick_mode_q <= cfg_data;
		end
	end

	scma_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (angle_valid),
		.func      (func),
		.quick     (quick_mode_q),
		.angle     (angle),
		.out_valid (r_valid),
		.out_quick (r_quick),
		.r         (r)
	);

	// u = r*r
	scma_mac #(.SIDE_W(1)) u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (r_valid),
		.a         (r),
		.b         (r),
		.addend    ('0),
		.dbl       (1'b0),
		.side_in   (r_quick),
		.out_valid (u_valid),
		.y         (u),
		.side_out  (u_quick)
	);

	assign hv[0] = u_valid;
	assign hq[0] = u_quick;
	assign hu[0] = u;
	assign hp[0] = COEF[6];

	// p = c[n] + p*u for n = 5 down to 0; quick mode zeroes the product
	// for the high terms so that p reaches c[2] unchanged
	for (genvar j = 0; j < 6; j++) begin : g_horner
		localparam int N = 5 - j;
		val_t b_in;
		assign b_in = (hq[j] && (N >= 2)) ? '0 : hu[j];
		scma_mac #(.SIDE_W(1 + VAL_W)) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (hv[j]),
			.a         (hp[j]),
			.b         (b_in),
			.addend    (COEF[N]),
			.dbl       (1'b0),
			.side_in   ({hq[j], hu[j]}),
			.out_valid (hv[j+1]),
			.y         (hp[j+1]),
			.side_out  ({hq[j+1], hu[j+1]})
		);
	end

	assign cv[0] = hv[6];
	assign cy[0] = hp[6];

	// three rounds of y = 2*y*y - 1 give cos(8r)
	for (genvar i = 0; i < 3; i++) begin : g_cheb
		scma_mac #(.SIDE_W(1)) u_sq (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cv[i]),
			.a         (cy[i]),
			.b         (cy[i]),
			.addend    (-ONE_V),
			.dbl       (1'b1),
			.side_in   (1'b0),
			.out_valid (cv[i+1]),
			.y         (cy[i+1]),
			.side_out  ()
		);
	end

	// round Q40 down to Q30 and saturate to plus or minus one
	assign ymag = cy[3][VAL_W-1] ? VAL_W'(-cy[3]) : VAL_W'(cy[3]);
	assign om   = 38'(ymag[VAL_W-1:FRAC-RES_FRAC]) + 38'(ymag[FRAC-RES_FRAC-1]);
	assign omc  = (om > (38'd1 << RES_FRAC)) ? (32'd1 << RES_FRAC) : om[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= cv[3];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= cy[3][VAL_W-1] ? -$signed(omc) : $signed(omc);
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// result stays within plus or minus one
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result <= (32'sd1 <<< RES_FRAC) && result >= -(32'sd1 <<< RES_FRAC)))
		else $error("result out of range");

	// input is held back only while an output is waiting
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		angle_stall |-> (result_valid && result_stall))
		else $error("input stalled without output backpressure");

	// a config write lands in quick mode
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (quick_mode_q == $past(cfg_data)))
		else $error("quick mode not updated");

endmodule
